[hw/rtl/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-32 decoder.
// No dependencies; imported by the decoder core and its checker.
package utf8d_pkg;

  // Characters allowed per buffer before decoding halts.
  localparam logic [5:0] OUTPUT_LIMIT = 6'd32;

  // Field widths.
  localparam int unsigned CP_W     = 31;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned REM_W    = 3;
  localparam int unsigned STATUS_W = 2;

  // Result data layout: code_point, status, char_count, zero fill to bytes.
  localparam int unsigned OUT_STATUS_LSB = CP_W;
  localparam int unsigned OUT_COUNT_LSB  = CP_W + STATUS_W;
  localparam int unsigned OUT_USED_W     = CP_W + STATUS_W + COUNT_W;
  localparam int unsigned OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  // End-of-buffer status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_LEAD  = 2'd1,
    STATUS_TRUNCATED = 2'd2,
    STATUS_LIMIT     = 2'd3
  } status_t;

endpackage

[hw/rtl/utf8_to_utf32_decoder_core.sv]
// Top level of the byte-serial UTF-8 to UTF-32 decoder (legacy six-byte forms).
// Depends on utf8d_pkg for field widths, the output limit and status codes.
//
// The decoder takes one byte per clock and gives a result in the cycle after the
// byte that causes it. Each byte goes through one level of lead-byte decode and
// a six-bit shift into the code point register, so the rate is one byte per
// cycle unless stalled; a single output register holds a result while the sink
// stalls, and input is taken whenever that register is empty or being drained.
// Lead bytes 110xxxxx through 1111110x start sequences of two to six bytes;
// continuation bytes contribute their low six bits without a check. A lone
// continuation byte, 0xFE or 0xFF halts decoding until the buffer's last byte,
// as does any byte outside a sequence after OUTPUT_LIMIT characters. The last
// byte always yields a result with tlast set and a status; all state then clears.
module utf8_to_utf32_decoder_core
  import utf8d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input byte stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // last_byte
  // Decoded result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [30:0] code_point, [32:31] status,
                                            // [38:33] char_count, [39] zero
  output logic                  out_tuser,  // char_valid
  output logic                  out_tlast   // end_of_buffer
);

  // Decoder state.
  logic [CP_W-1:0]    acc_r, acc_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               stopped_r, stopped_nxt;
  status_t            cause_r, cause_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // Output register.
  logic               out_valid_r;
  logic [CP_W-1:0]    out_cp_r;
  status_t            out_status_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_char_r;
  logic               out_last_r;

  logic               in_xfer;
  logic [3:0]         lead_ones;
  logic [CP_W-1:0]    acc_shift;
  logic               have_char;
  logic [CP_W-1:0]    cp;
  status_t            status;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Count the leading ones of the incoming byte.
  always_comb begin
    unique casez (in_tdata)
      8'b0???????: lead_ones = 4'd0;
      8'b10??????: lead_ones = 4'd1;
      8'b110?????: lead_ones = 4'd2;
      8'b1110????: lead_ones = 4'd3;
      8'b11110???: lead_ones = 4'd4;
      8'b111110??: lead_ones = 4'd5;
      8'b1111110?: lead_ones = 4'd6;
      8'b11111110: lead_ones = 4'd7;
      default:     lead_ones = 4'd8;
    endcase
  end

  assign acc_shift = {acc_r[CP_W-7:0], in_tdata[5:0]};

  // Decode step: next state, completed character and end status.
  always_comb begin
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    stopped_nxt = stopped_r;
    cause_nxt   = cause_r;
    count_nxt   = count_r;
    have_char   = 1'b0;
    cp          = '0;

    if (!stopped_r) begin
      if (rem_r != '0) begin
        acc_nxt = acc_shift;
        rem_nxt = rem_r - REM_W'(1);
        if (rem_r == REM_W'(1)) begin
          have_char = 1'b1;
          cp        = acc_shift;
        end
      end else if (count_r >= OUTPUT_LIMIT) begin
        stopped_nxt = 1'b1;
        cause_nxt   = STATUS_LIMIT;
      end else if (lead_ones == 4'd0) begin
        have_char = 1'b1;
        cp        = CP_W'(in_tdata);
      end else if (lead_ones == 4'd1 || lead_ones > 4'd6) begin
        stopped_nxt = 1'b1;
        cause_nxt   = STATUS_BAD_LEAD;
      end else begin
        // Lead byte keeps its low (7 - ones) bits.
        acc_nxt = CP_W'(in_tdata[6:0] & (7'h7f >> lead_ones));
        rem_nxt = REM_W'(lead_ones - 4'd1);
      end
      if (have_char) begin
        count_nxt = count_r + COUNT_W'(1);
        acc_nxt   = '0;
      end
    end

    // Status is reported only on the last byte.
    status = STATUS_OK;
    if (in_tlast) begin
      if (stopped_nxt) begin
        status = cause_nxt;
      end else if (rem_nxt != '0) begin
        status = STATUS_TRUNCATED;
      end
    end
  end

  // State update; the last byte of a buffer clears everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      rem_r     <= '0;
      stopped_r <= 1'b0;
      cause_r   <= STATUS_OK;
      count_r   <= '0;
    end else if (in_xfer) begin
      if (in_tlast) begin
        acc_r     <= '0;
        rem_r     <= '0;
        stopped_r <= 1'b0;
        cause_r   <= STATUS_OK;
        count_r   <= '0;
      end else begin
        acc_r     <= acc_nxt;
        rem_r     <= rem_nxt;
        stopped_r <= stopped_nxt;
        cause_r   <= cause_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && (have_char || in_tlast)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload, loaded with each result.
  always_ff @(posedge clk) begin
    if (in_xfer && (have_char || in_tlast)) begin
      out_cp_r     <= cp;
      out_status_r <= status;
      out_count_r  <= count_nxt;
      out_char_r   <= have_char;
      out_last_r   <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_count_r, out_status_r, out_cp_r};
  assign out_tuser  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

[hw/rtl/utf8d_checker.sv]
// Port-level checker for the UTF-8 decoder core, attached by bind.
// Depends on utf8d_pkg for the result data layout and status codes.
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  // A stalled result holds until its transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A result without a character appears only at the end of a buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("empty result before end of buffer");

  // Status is nonzero only on the end-of-buffer result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      out_tdata[OUT_COUNT_LSB-1:OUT_STATUS_LSB] == STATUS_OK)
    else $error("status set before end of buffer");

  // The code point is zero when no character is carried.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[CP_W-1:0] == '0)
    else $error("code point set without a character");

  // A carried character is always counted.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_USED_W-1:OUT_COUNT_LSB] != '0)
    else $error("character count zero on a character result");

endmodule

bind utf8_to_utf32_decoder_core utf8d_checker u_utf8d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
